@@ sv/bps_pkg.sv @@
package bps_pkg;

  // sample and field widths
  localparam int SAMPLE_W       = 32;
  localparam int IDX_W          = 16;
  localparam int GL_W           = 17;
  localparam int CR_W           = 32;
  localparam int TV_W           = 48;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int MAX_POINTS_DEF = 65536;

  // job queue between front and back, power of two
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCHEME_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COURANT_RATIO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_LENGTH   = 2'd2;

  // register reset values
  localparam logic                  SCHEME_MODE_RST   = 1'b0;
  localparam logic [CR_W-1:0]       COURANT_RATIO_RST = 32'd32768;
  localparam logic [GL_W-1:0]       GRID_LENGTH_RST   = 17'd1024;

  // one stencil update: left and right neighbours, previous-level center
  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] old;
    logic [IDX_W-1:0]    idx;
    logic                first_flag;
    logic                last_flag;
  } job_t;

endpackage

@@ sv/bps_front.sv @@
module bps_front #(
  parameter int MAX_POINTS = bps_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [bps_pkg::GL_W-1:0]        grid_length,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [bps_pkg::SAMPLE_W-1:0] in_u_now,
  input  logic signed [bps_pkg::SAMPLE_W-1:0] in_u_prev,
  output logic                            push_valid,
  output bps_pkg::job_t                   push_job,
  input  logic                            q_full
);
  import bps_pkg::*;

  typedef enum logic [2:0] {
    F_RUN    = 3'b001,
    F_WRAP_K = 3'b010,
    F_WRAP_0 = 3'b100
  } fstate_t;

  localparam int GL_MAX = (1 << GL_W) - 1;
  localparam int N_CAP  = (MAX_POINTS > GL_MAX) ? GL_MAX : MAX_POINTS;

  fstate_t st_r, st_nxt;
  logic [GL_W-1:0] k_r, k_nxt;
  logic [GL_W-1:0] k_m1;
  logic [GL_W-1:0] n_eff;
  logic [GL_W:0]   k_p1;
  logic            sweep_end;
  logic            accept;

  logic [SAMPLE_W-1:0] win0_r, win1_r, win_prev_r;
  logic [SAMPLE_W-1:0] head0_r, head1_r, head_prev_r;
  logic [SAMPLE_W-1:0] un_l_r, uo_l_r;
  logic [IDX_W-1:0]    wrap_idx_r;

  always_comb begin
    if (grid_length < GL_W'(3)) begin
      n_eff = GL_W'(3);
    end else if (grid_length > GL_W'(N_CAP)) begin
      n_eff = GL_W'(N_CAP);
    end else begin
      n_eff = grid_length;
    end
  end

  assign k_p1      = {1'b0, k_r} + (GL_W+1)'(1);
  assign sweep_end = k_p1 >= {1'b0, n_eff};
  assign k_m1      = k_r - GL_W'(1);
  assign in_ready  = (st_r == F_RUN) && !q_full;
  assign accept    = in_valid && in_ready;

  always_comb begin
    push_valid = 1'b0;
    push_job   = '0;
    unique case (st_r)
      F_RUN: begin
        push_valid          = accept && (k_r >= GL_W'(2));
        push_job.left       = win0_r;
        push_job.right      = in_u_now;
        push_job.old        = win_prev_r;
        push_job.idx        = k_m1[IDX_W-1:0];
        push_job.first_flag = (k_r == GL_W'(2));
        push_job.last_flag  = 1'b0;
      end
      F_WRAP_K: begin
        push_valid          = !q_full;
        push_job.left       = win1_r;
        push_job.right      = head0_r;
        push_job.old        = uo_l_r;
        push_job.idx        = wrap_idx_r;
        push_job.first_flag = 1'b0;
        push_job.last_flag  = 1'b0;
      end
      F_WRAP_0: begin
        push_valid          = !q_full;
        push_job.left       = un_l_r;
        push_job.right      = head1_r;
        push_job.old        = head_prev_r;
        push_job.idx        = '0;
        push_job.first_flag = 1'b0;
        push_job.last_flag  = 1'b1;
      end
      default: begin
        push_valid = 1'b0;
        push_job   = '0;
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    k_nxt  = k_r;
    unique case (st_r)
      F_RUN: begin
        if (accept) begin
          if (sweep_end) begin
            st_nxt = F_WRAP_K;
            k_nxt  = '0;
          end else begin
            k_nxt = k_p1[GL_W-1:0];
          end
        end
      end
      F_WRAP_K: begin
        if (!q_full) st_nxt = F_WRAP_0;
      end
      F_WRAP_0: begin
        if (!q_full) st_nxt = F_RUN;
      end
      default: st_nxt = F_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_RUN;
      k_r  <= '0;
    end else begin
      st_r <= st_nxt;
      k_r  <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (k_r == '0) begin
        head0_r     <= in_u_now;
        head_prev_r <= in_u_prev;
      end
      if (k_r == GL_W'(1)) head1_r <= in_u_now;
      if (!sweep_end) begin
        win0_r     <= win1_r;
        win1_r     <= in_u_now;
        win_prev_r <= in_u_prev;
      end else begin
        un_l_r     <= in_u_now;
        uo_l_r     <= in_u_prev;
        wrap_idx_r <= k_r[IDX_W-1:0];
      end
    end
  end

endmodule

@@ sv/bps_queue.sv @@
module bps_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  bps_pkg::job_t push_job,
  output logic          q_full,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bps_pkg::job_t pop_job
);
  import bps_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push, do_pop;

  assign q_full    = cnt_r == (PTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid = cnt_r != '0;
  assign pop_job   = slot_r[rd_ptr_r];
  assign do_push   = push_valid && !q_full;
  assign do_pop    = pop_ready && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (PTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

@@ sv/bps_back.sv @@
module bps_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              scheme_mode,
  input  logic [bps_pkg::CR_W-1:0]          courant_ratio,
  input  logic                              q_valid,
  input  bps_pkg::job_t                     q_job,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bps_pkg::IDX_W-1:0]         out_point_index,
  output logic signed [bps_pkg::SAMPLE_W-1:0] out_u_next,
  output logic                              out_sweep_done,
  output logic [bps_pkg::CR_W-1:0]          out_courant_number,
  output logic [bps_pkg::TV_W-1:0]          out_total_variation
);
  import bps_pkg::*;

  localparam int SW      = SAMPLE_W;
  localparam int P_W     = 2 * SW;
  localparam int M_W     = SW + CR_W;
  localparam int Q_W     = P_W + CR_W;
  localparam int T_W     = Q_W + 2;
  localparam int SH_LEAP = 33;
  localparam int SH_LF   = 34;
  localparam int S_W     = T_W - SH_LEAP;
  localparam int PAD_OLD = T_W - SW - SH_LEAP;
  localparam int PAD_SUM = T_W - (SW + 1) - SH_LEAP;
  localparam int CN_SH   = 16;
  localparam int CF_W    = SW + CR_W;

  localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  typedef enum logic [10:0] {
    B_IDLE    = 11'b00000000001,
    B_MUL_P   = 11'b00000000010,
    B_MUL_LO  = 11'b00000000100,
    B_MUL_HI  = 11'b00000001000,
    B_ACC     = 11'b00000010000,
    B_DIFF    = 11'b00000100000,
    B_SAT     = 11'b00001000000,
    B_STAT    = 11'b00010000000,
    B_EMIT    = 11'b00100000000,
    B_FIN     = 11'b01000000000,
    B_FIN_OUT = 11'b10000000000
  } bstate_t;

  function automatic logic [SW-1:0] abs_diff(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] d;
    logic [SW:0] n;
    d = {a[SW-1], a} - {b[SW-1], b};
    n = -d;
    return d[SW] ? n[SW-1:0] : d[SW-1:0];
  endfunction

  function automatic logic [TV_W-1:0] tv_add(input logic [TV_W-1:0] acc, input logic [SW-1:0] a);
    logic [TV_W:0] s;
    s = {1'b0, acc} + {{(TV_W+1-SW){1'b0}}, a};
    return s[TV_W] ? {TV_W{1'b1}} : s[TV_W-1:0];
  endfunction

  bstate_t st_r, st_nxt;

  // operand capture
  logic [SW-1:0]  dif_abs_r;
  logic [SW:0]    sum_abs_r;
  logic [SW:0]    sum_r;
  logic [SW-1:0]  old_r;
  logic           neg_r;
  logic [IDX_W-1:0] idx_r;
  logic           first_job_r, last_job_r;

  // product chain
  logic [P_W-1:0] p_r;
  logic [M_W-1:0] ql_r, qh_r;
  logic [Q_W-1:0] q_r;
  logic [T_W-1:0] t_r;
  logic [SW-1:0]  u_r;
  logic [CF_W-1:0] cfl_r;

  // sweep statistics
  logic [SW-1:0]   max_r;
  logic [TV_W-1:0] tv_r;
  logic [SW-1:0]   first_u_r, last_u_r;

  logic            out_valid_r, out_done_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [SW-1:0]   out_u_r;
  logic [CR_W-1:0] out_cn_r;
  logic [TV_W-1:0] out_tv_r;

  logic [SW:0]     dif_w, sum_w, dif_neg_w, sum_neg_w;
  logic [SW-1:0]   dif_abs_w;
  logic [SW:0]     sum_abs_w;
  logic [P_W-1:0]  p_full;
  logic [M_W-1:0]  ql_w, qh_w;
  logic [Q_W-1:0]  q_w;
  logic [T_W-1:0]  base_w, qx_w, t_w;
  logic [S_W-1:0]  sh_w;
  logic            fits_w;
  logic [SW-1:0]   sat_w;
  logic [SW-1:0]   u_abs_w;
  logic [CF_W-1:0] cfl_w;
  logic [CR_W-1:0] cn_w;
  logic            out_free, out_wr, fin_wr;

  // neighbour difference and sum, magnitudes and product sign
  assign dif_w     = {q_job.right[SW-1], q_job.right} - {q_job.left[SW-1], q_job.left};
  assign sum_w     = {q_job.right[SW-1], q_job.right} + {q_job.left[SW-1], q_job.left};
  assign dif_neg_w = -dif_w;
  assign sum_neg_w = -sum_w;
  assign dif_abs_w = dif_w[SW] ? dif_neg_w[SW-1:0] : dif_w[SW-1:0];
  assign sum_abs_w = sum_w[SW] ? sum_neg_w : sum_w;

  // |a-b|*|a+b| stays below 2^64, then times the courant ratio in two 32-bit halves
  assign p_full = P_W'(dif_abs_r) * P_W'(sum_abs_r);
  assign ql_w   = M_W'(p_r[SW-1:0]) * M_W'(courant_ratio);
  assign qh_w   = M_W'(p_r[P_W-1:SW]) * M_W'(courant_ratio);
  assign q_w    = {qh_r, {SW{1'b0}}} + {{SW{1'b0}}, ql_r};

  assign base_w = scheme_mode ? {{PAD_OLD{old_r[SW-1]}}, old_r, {SH_LEAP{1'b0}}}
                              : {{PAD_SUM{sum_r[SW]}}, sum_r, {SH_LEAP{1'b0}}};
  assign qx_w   = {2'b00, q_r};
  assign t_w    = base_w + (neg_r ? qx_w : -qx_w);

  // floor division by shift, then clamp to the sample range
  assign sh_w   = scheme_mode ? t_r[T_W-1:SH_LEAP] : {t_r[T_W-1], t_r[T_W-1:SH_LF]};
  assign fits_w = (&sh_w[S_W-1:SW-1]) || !(|sh_w[S_W-1:SW-1]);
  assign sat_w  = fits_w ? sh_w[SW-1:0] : (sh_w[S_W-1] ? SMIN : SMAX);

  assign u_abs_w = abs_diff(u_r, '0);
  assign cfl_w   = CF_W'(max_r) * CF_W'(courant_ratio);
  assign cn_w    = (|cfl_r[CF_W-1:CN_SH+CR_W]) ? {CR_W{1'b1}} : cfl_r[CN_SH+CR_W-1:CN_SH];

  assign out_free = !out_valid_r || out_ready;
  assign fin_wr   = (st_r == B_FIN_OUT) && out_free;
  assign out_wr   = ((st_r == B_EMIT) && out_free) || fin_wr;
  assign q_pop    = (st_r == B_IDLE) && q_valid;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE:    if (q_valid) st_nxt = B_MUL_P;
      B_MUL_P:   st_nxt = B_MUL_LO;
      B_MUL_LO:  st_nxt = B_MUL_HI;
      B_MUL_HI:  st_nxt = B_ACC;
      B_ACC:     st_nxt = B_DIFF;
      B_DIFF:    st_nxt = B_SAT;
      B_SAT:     st_nxt = B_STAT;
      B_STAT:    st_nxt = last_job_r ? B_FIN : B_EMIT;
      B_EMIT:    if (out_free) st_nxt = B_IDLE;
      B_FIN:     st_nxt = B_FIN_OUT;
      B_FIN_OUT: if (out_free) st_nxt = B_IDLE;
      default:   st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
      max_r       <= '0;
      tv_r        <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_wr) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (st_r == B_STAT) begin
        if (u_abs_w > max_r) max_r <= u_abs_w;
        if (!first_job_r) tv_r <= tv_add(tv_r, abs_diff(u_r, last_u_r));
      end else if (st_r == B_FIN) begin
        tv_r <= tv_add(tv_r, abs_diff(first_u_r, last_u_r));
      end else if (fin_wr) begin
        max_r <= '0;
        tv_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dif_abs_r   <= dif_abs_w;
      sum_abs_r   <= sum_abs_w;
      sum_r       <= sum_w;
      old_r       <= q_job.old;
      neg_r       <= dif_w[SW] ^ sum_w[SW];
      idx_r       <= q_job.idx;
      first_job_r <= q_job.first_flag;
      last_job_r  <= q_job.last_flag;
    end
    if (st_r == B_MUL_P)  p_r  <= p_full;
    if (st_r == B_MUL_LO) ql_r <= ql_w;
    if (st_r == B_MUL_HI) qh_r <= qh_w;
    if (st_r == B_ACC)    q_r  <= q_w;
    if (st_r == B_DIFF)   t_r  <= t_w;
    if (st_r == B_SAT)    u_r  <= sat_w;
    if (st_r == B_STAT) begin
      last_u_r <= u_r;
      if (first_job_r) first_u_r <= u_r;
    end
    if (st_r == B_FIN) cfl_r <= cfl_w;
    if (out_wr) begin
      out_idx_r  <= idx_r;
      out_u_r    <= u_r;
      out_done_r <= fin_wr;
      out_cn_r   <= fin_wr ? cn_w : '0;
      out_tv_r   <= fin_wr ? tv_r : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_point_index     = out_idx_r;
  assign out_u_next          = out_u_r;
  assign out_sweep_done      = out_done_r;
  assign out_courant_number  = out_cn_r;
  assign out_total_variation = out_tv_r;

endmodule

@@ sv/burgers_periodic_stencil_step_top.sv @@
// One time step of the 1D inviscid Burgers equation (flux u*u/2) on a periodic grid, Q16.16
// fixed point with saturation. Samples of the current level stream in by grid index 0..N-1,
// each with the previous-level sample at that index (used only in leapfrog mode). Updated
// samples leave in index order 1..N-1 and then 0; the input of index N-1 causes three
// results, and the last one of a sweep carries sweep_done, the CFL number max|u_new|*dt/dx
// and the total variation of the new level. Mode 0 is Lax-Friedrichs, mode 1 leapfrog.
// Timing: the input side takes one sample per cycle as long as the four-entry job queue has
// room, and holds off after the last sample of a sweep while it queues the two wrap-around
// jobs; the update unit then works on one result at a time, through the chain of registered
// multiplies (|a-b|*|a+b|, then two 32x32 halves times dt/dx) and the add, shift and clamp
// steps behind it, with an extra step on the last result of a sweep for the CFL multiply and
// the variation wrap term. Configuration is to be written only while the block is idle; the
// block itself does not enforce this. grid_length below 3 counts as 3, above MAX_POINTS as
// MAX_POINTS.
module burgers_periodic_stencil_step_top #(
  parameter int MAX_POINTS = bps_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input samples
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bps_pkg::SAMPLE_W-1:0] in_u_now,
  input  logic signed [bps_pkg::SAMPLE_W-1:0] in_u_prev,
  // updated samples
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bps_pkg::IDX_W-1:0]           out_point_index,
  output logic signed [bps_pkg::SAMPLE_W-1:0] out_u_next,
  output logic                                out_sweep_done,
  output logic [bps_pkg::CR_W-1:0]            out_courant_number,
  output logic [bps_pkg::TV_W-1:0]            out_total_variation
);
  import bps_pkg::*;

  // configuration registers
  logic            scheme_mode_r;
  logic [CR_W-1:0] courant_ratio_r;
  logic [GL_W-1:0] grid_length_r;

  // front to queue, queue to back
  logic push_valid, q_full;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_mode_r   <= SCHEME_MODE_RST;
      courant_ratio_r <= COURANT_RATIO_RST;
      grid_length_r   <= GRID_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCHEME_MODE:   scheme_mode_r   <= cfg_wdata[0];
        CFG_COURANT_RATIO: courant_ratio_r <= cfg_wdata[CR_W-1:0];
        CFG_GRID_LENGTH:   grid_length_r   <= cfg_wdata[GL_W-1:0];
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // front: tracks the sliding window and the wrap-around head samples, turns accepted
  // samples from index 2 on into stencil jobs (three on the last sample of a sweep)
  bps_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .grid_length (grid_length_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_u_now    (in_u_now),
    .in_u_prev   (in_u_prev),
    .push_valid  (push_valid),
    .push_job    (push_job),
    .q_full      (q_full)
  );

  // short job queue so the input side keeps taking samples while updates run
  bps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .q_full     (q_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // back: multi-cycle flux update, sweep statistics and the output register
  bps_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .scheme_mode         (scheme_mode_r),
    .courant_ratio       (courant_ratio_r),
    .q_valid             (pop_valid),
    .q_job               (pop_job),
    .q_pop               (pop_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_point_index     (out_point_index),
    .out_u_next          (out_u_next),
    .out_sweep_done      (out_sweep_done),
    .out_courant_number  (out_courant_number),
    .out_total_variation (out_total_variation)
  );

endmodule

@@ verif/tb_burgers_periodic_stencil_step_top.sv @@
module tb_burgers_periodic_stencil_step_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;

  // no-transfer cycles before the run is declared hung; well above the gap that one
  // 3-result item plus receiver stalls leaves in a correct run
  localparam int WATCHDOG_LIMIT = 5000;
  // quiet time once nothing is expected: covers the update chain plus
  // the end-of-sweep cfl and variation steps
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 350;
  localparam logic [63:0] TV_SAT = (64'd1 << TV_W) - 64'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] u_now;
    logic signed [SAMPLE_W-1:0] u_prev;
  } sample_t;

  typedef struct packed {
    logic [IDX_W-1:0]           point_index;
    logic signed [SAMPLE_W-1:0] u_next;
    logic                       sweep_done;
    logic [CR_W-1:0]            courant_number;
    logic [TV_W-1:0]            total_variation;
  } update_t;

  // dut ports; the inputs are all driven to known values from time zero
  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_u_now  = '0;
  logic signed [SAMPLE_W-1:0] in_u_prev = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [IDX_W-1:0]           out_point_index;
  logic signed [SAMPLE_W-1:0] out_u_next;
  logic                       out_sweep_done;
  logic [CR_W-1:0]            out_courant_number;
  logic [TV_W-1:0]            out_total_variation;

  // stimulus bookkeeping
  sample_t     pending_samples[$];
  sample_t     on_wire;
  update_t     expected_updates[$];
  int unsigned queued_items  = 0;
  int unsigned sent_items    = 0;
  int unsigned quiet_cycles  = 0;
  int          fail_count    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // predictor copy of the registers
  logic            mdl_mode;
  logic [CR_W-1:0] mdl_courant;
  logic [GL_W-1:0] mdl_length;

  // predictor copy of the sweep state
  logic signed [SAMPLE_W-1:0] win_u[2];
  logic signed [SAMPLE_W-1:0] head_u[2];
  logic signed [SAMPLE_W-1:0] head_prev;
  logic signed [SAMPLE_W-1:0] win_prev;
  logic signed [SAMPLE_W-1:0] first_new;
  logic signed [SAMPLE_W-1:0] last_new;
  int unsigned                taken;
  logic [63:0]                peak_abs;
  logic [63:0]                variation;

  burgers_periodic_stencil_step_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_u_now            (in_u_now),
    .in_u_prev           (in_u_prev),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_point_index     (out_point_index),
    .out_u_next          (out_u_next),
    .out_sweep_done      (out_sweep_done),
    .out_courant_number  (out_courant_number),
    .out_total_variation (out_total_variation)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // one stencil update, exact in 128 bits, then floor shift and clamp
  // lax-friedrichs: ((l+r)*2^33 - c*(r*r-l*l)) >> 34
  // leapfrog:       (old*2^33   - c*(r*r-l*l)) >> 33
  function automatic logic signed [SAMPLE_W-1:0] stencil_value(
    input logic signed [SAMPLE_W-1:0] left,
    input logic signed [SAMPLE_W-1:0] right,
    input logic signed [SAMPLE_W-1:0] old
  );
    logic signed [127:0] l, r, o, dif, sum, flux, acc;
    l = left;
    r = right;
    o = old;
    dif = r - l;
    sum = r + l;
    flux = dif * sum * $signed({96'd0, mdl_courant});
    if (mdl_mode) begin
      acc = ((o <<< 33) - flux) >>> 33;
    end else begin
      acc = ((sum <<< 33) - flux) >>> 34;
    end
    if (acc > 128'sd2147483647) return {1'b0, {(SAMPLE_W-1){1'b1}}};
    if (acc < -128'sd2147483648) return {1'b1, {(SAMPLE_W-1){1'b0}}};
    return acc[SAMPLE_W-1:0];
  endfunction

  task automatic clear_sweep_state;
    win_u[0]  = '0;
    win_u[1]  = '0;
    head_u[0] = '0;
    head_u[1] = '0;
    head_prev = '0;
    win_prev  = '0;
    first_new = '0;
    last_new  = '0;
    taken     = 0;
    peak_abs  = '0;
    variation = '0;
  endtask

  // queue one new sample and fold it into the sweep statistics
  task automatic record_update(
    input logic [31:0]                idx,
    input logic signed [SAMPLE_W-1:0] u,
    input bit                         first
  );
    update_t          e;
    logic signed [63:0] w;
    w = u;
    if (magnitude(w) > peak_abs) peak_abs = magnitude(w);
    if (first) begin
      first_new = u;
    end else begin
      variation = variation + magnitude(w - last_new);
      if (variation > TV_SAT) variation = TV_SAT;
    end
    last_new = u;
    e = '0;
    e.point_index = idx[IDX_W-1:0];
    e.u_next      = u;
    expected_updates.insert(expected_updates.size(), e);
  endtask

  // advance the stencil window by one accepted sample
  task automatic advance_stencil(input sample_t s);
    int unsigned        k, n;
    update_t            e;
    logic [95:0]        cfl;
    logic signed [63:0] wrap;
    k = taken;
    n = mdl_length;
    if (n < 3) n = 3;
    if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
    if (k == 0) begin
      head_u[0] = s.u_now;
      head_prev = s.u_prev;
    end
    if (k == 1) head_u[1] = s.u_now;
    if (k >= 2) record_update(k - 1, stencil_value(win_u[0], s.u_now, win_prev), k == 2);
    if (k + 1 >= n) begin
      // sweep ends here: last index, then index 0 wrapping onto the held head
      record_update(k, stencil_value(win_u[1], head_u[0], s.u_prev), 1'b0);
      record_update(0, stencil_value(s.u_now, head_u[1], head_prev), 1'b0);
      wrap = first_new - last_new;
      variation = variation + magnitude(wrap);
      if (variation > TV_SAT) variation = TV_SAT;
      cfl = peak_abs;
      cfl = cfl * mdl_courant;
      cfl = cfl >> 16;
      e = expected_updates.pop_back();
      e.sweep_done      = 1'b1;
      e.courant_number  = (cfl > 96'hFFFF_FFFF) ? '1 : cfl[CR_W-1:0];
      e.total_variation = variation[TV_W-1:0];
      expected_updates.insert(expected_updates.size(), e);
      clear_sweep_state();
    end else begin
      win_u[0] = win_u[1];
      win_u[1] = s.u_now;
      win_prev = s.u_prev;
      taken    = k + 1;
    end
  endtask

  task automatic check_update;
    update_t want, got;
    got.point_index     = out_point_index;
    got.u_next          = out_u_next;
    got.sweep_done      = out_sweep_done;
    got.courant_number  = out_courant_number;
    got.total_variation = out_total_variation;
    if (expected_updates.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("unexpected update: idx %0d u %h done %b cfl %h tv %h",
                 got.point_index, got.u_next, got.sweep_done,
                 got.courant_number, got.total_variation);
    end else begin
      want = expected_updates.pop_front();
      if (got.point_index !== want.point_index || got.u_next !== want.u_next ||
          got.sweep_done !== want.sweep_done ||
          got.courant_number !== want.courant_number ||
          got.total_variation !== want.total_variation) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("update mismatch, want: idx %0d u %h done %b cfl %h tv %h",
                   want.point_index, want.u_next, want.sweep_done,
                   want.courant_number, want.total_variation);
          $display("                  got: idx %0d u %h done %b cfl %h tv %h",
                   got.point_index, got.u_next, got.sweep_done,
                   got.courant_number, got.total_variation);
        end
      end
    end
  endtask

  // sample driver: predicts on each input transfer, then presents the next
  // pending sample unless it decides to idle this cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_stencil(on_wire);
        sent_items++;
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = pending_samples.pop_front();
          in_valid  <= 1'b1;
          in_u_now  <= on_wire.u_now;
          in_u_prev <= on_wire.u_prev;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_update();
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // hang detector: cycles without any transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // block until every queued sample is taken and every update has come back,
  // then let the update chain drain; this is also where the sender holds off
  task automatic wait_quiet;
    @(negedge clk);
    while (sent_items != queued_items || expected_updates.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // all three registers, back to back with the write enable held high
  task automatic write_config(
    input logic            mode,
    input logic [CR_W-1:0] ratio,
    input logic [GL_W-1:0] length
  );
    wait_quiet();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCHEME_MODE;
    cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, mode};
    @(posedge clk);
    cfg_index <= CFG_COURANT_RATIO;
    cfg_wdata <= ratio;
    @(posedge clk);
    cfg_index <= CFG_GRID_LENGTH;
    cfg_wdata <= {{(CFG_DATA_W-GL_W){1'b0}}, length};
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_mode    = mode;
    mdl_courant = ratio;
    mdl_length  = length;
    @(negedge clk);
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] now, input logic [SAMPLE_W-1:0] prev);
    sample_t s;
    s.u_now  = now;
    s.u_prev = prev;
    pending_samples.insert(pending_samples.size(), s);
    queued_items++;
  endtask

  // samples within +-2.0 most often, some up to +-64, some raw or extreme
  function automatic logic [SAMPLE_W-1:0] pick_sample;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return $urandom_range(0, 262144) - 131072;
    if (r < 65) return $urandom_range(0, 1 << 23) - (1 << 22);
    if (r < 85) return $urandom;
    case ($urandom_range(4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [CR_W-1:0] pick_ratio;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 30) return 32'd32768;
    if (r < 60) return $urandom_range(0, 65536);
    if (r < 80) return $urandom_range(0, 1 << 20);
    return $urandom;
  endfunction

  // mostly short grids; a few huge ones that get cut short by a later shrink
  function automatic logic [GL_W-1:0] pick_length;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return GL_W'($urandom_range(0, 2));
    if (r < 88) return GL_W'($urandom_range(3, 12));
    if (r < 95) return GL_W'($urandom_range(13, 40));
    case ($urandom_range(2))
      0:       return 17'd65536;
      1:       return 17'h1FFFF;
      default: return GL_W'($urandom_range(65537, 131070));
    endcase
  endfunction

  initial begin
    int unsigned     rand_items;
    int unsigned     n_eff;
    int unsigned     remain;
    int unsigned     count;
    logic [GL_W-1:0] length;

    mdl_mode    = SCHEME_MODE_RST;
    mdl_courant = COURANT_RATIO_RST;
    mdl_length  = GRID_LENGTH_RST;
    clear_sweep_state();
    send_idle_pct = 7;
    recv_idle_pct = 52;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // lax-friedrichs on the shortest grid (length 0 counts as 3), full-scale
    // samples of both signs
    write_config(1'b0, 32'd32768, 17'd0);
    push_sample(32'h0000_0000, 32'h0000_0000);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000);
    push_sample(32'h8000_0000, 32'h7FFF_FFFF);

    // leapfrog at the largest dt/dx: both saturation directions
    write_config(1'b1, 32'hFFFF_FFFF, 17'd1);
    push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_sample(32'h8000_0000, 32'h8000_0000);
    push_sample(32'h0000_0001, 32'hFFFF_FFFF);

    // zero dt/dx: plain neighbour average, u_prev must not matter
    write_config(1'b0, 32'd0, 17'd2);
    push_sample(32'h8000_0000, 32'h0000_0000);
    push_sample(32'h8000_0000, 32'hFFFF_FFFF);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000);

    // leapfrog, dt/dx = 1.0, a smooth short wave
    write_config(1'b1, 32'd65536, 17'd5);
    push_sample(32'h0001_0000, 32'h0001_0400);
    push_sample(32'h0000_8000, 32'h0000_8800);
    push_sample(32'h0000_0000, 32'h0000_0100);
    push_sample(32'hFFFF_8000, 32'hFFFF_7800);
    push_sample(32'hFFFF_0000, 32'hFFFF_0400);

    // grid length at the top of the field (clamped to max points), then a
    // shrink below the samples already taken so the next input ends the sweep
    write_config(1'b0, 32'd32768, 17'h1FFFF);
    repeat (4) push_sample(pick_sample(), pick_sample());
    write_config(1'b0, 32'd32768, 17'd3);
    push_sample(pick_sample(), pick_sample());
    push_sample(pick_sample(), pick_sample());

    // random sweeps; every phase boundary pauses the sender until all
    // expected updates are back
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 7;
        recv_idle_pct = 52;
      end else if (rand_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      length = pick_length();
      write_config(1'($urandom_range(1)), pick_ratio(), length);
      n_eff = length;
      if (n_eff < 3) n_eff = 3;
      if (n_eff > MAX_POINTS_DEF) n_eff = MAX_POINTS_DEF;
      remain = (n_eff > taken) ? n_eff - taken : 1;
      if (n_eff > 64) begin
        // huge grid: only a partial sweep, a later phase shrinks it
        count = $urandom_range(2, 6);
      end else if ($urandom_range(99) < 80) begin
        count = remain;
      end else begin
        // broken sweep: stop early or run on into the next one
        count = $urandom_range(1, remain + 3);
      end
      repeat (count) push_sample(pick_sample(), pick_sample());
      rand_items += count;
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
